// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the blitter modules.
// Both expect signals named clk and rst_n in the calling module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define RSB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define RSB_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- rtl/rsb_pkg.sv -----
package rsb_pkg;

  localparam int MAX_IMG_W_DEF = 128;
  localparam int MAX_IMG_H_DEF = 128;

  localparam int JOB_Q_DEPTH = 8;
  localparam int OUT_Q_DEPTH = 4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam int COORD_W    = 10;
  localparam int RGBA_W     = 32;
  localparam int COLOR_W    = 16;
  localparam int SIZE_W     = 8;
  localparam int CENTER_W   = 16;
  localparam int STEP_W     = 24;
  localparam int DELTA_W    = COORD_W + 4 + 3;
  localparam int PROD_W     = DELTA_W + STEP_W;
  localparam int MAP_W      = PROD_W + 2;
  localparam int FRAC_W     = 20;
  localparam int HALF_SHIFT = 19;

  localparam logic signed [STEP_W-1:0] STEP_COS_RST = 24'sd65536;

  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_DRAW = 1'b1
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X     = 3'd0,
    CFG_CENTER_Y     = 3'd1,
    CFG_STEP_COS     = 3'd2,
    CFG_STEP_SIN     = 3'd3,
    CFG_IMAGE_WIDTH  = 3'd4,
    CFG_IMAGE_HEIGHT = 3'd5
  } cfg_reg_t;

  // Handoff from the mapping front end into the job queue.
  typedef struct packed {
    logic valid;
    logic write;
  } job_ctl_t;

  // Index width for a table of n entries, never below one bit.
  function automatic int idx_bits(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  // RGBA8888 to RGB565 by truncation; alpha is dropped.
  function automatic logic [COLOR_W-1:0] rgb565(input logic [RGBA_W-1:0] rgba);
    return {rgba[31:27], rgba[23:18], rgba[15:11]};
  endfunction

endpackage

// ----- rtl/rotozoom_sprite_blitter.sv -----
// A drawn pixel passes the three mapping stages, the job queue, the read register and the result queue.
// Throughput: one item per cycle, loads and renders mixed; full rises only when the
// eight-entry job queue and the three mapping stages hold eight items between them.
// Loads and renders that miss the sprite give no result but flow through the same pipe.
// Reset (rst_n low, synchronous) empties all queues and restores the registers;
// the texel memory keeps its contents and is undefined until loaded.
`include "assert_macros.svh"

module rotozoom_sprite_blitter import rsb_pkg::*; #(
  parameter int MAX_IMG_W = MAX_IMG_W_DEF,
  parameter int MAX_IMG_H = MAX_IMG_H_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration writes.
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // Item input.
  input  logic                  push,
  output logic                  full,
  input  logic                  in_func,
  input  logic [COORD_W-1:0]    in_col,
  input  logic [COORD_W-1:0]    in_row,
  input  logic [RGBA_W-1:0]     in_rgba,
  // Result output.
  output logic                  empty,
  input  logic                  pop,
  output logic [COORD_W-1:0]    out_screen_col,
  output logic [COORD_W-1:0]    out_screen_row,
  output logic [COLOR_W-1:0]    out_color
);

  localparam int ADDR_W = idx_bits(MAX_IMG_W * MAX_IMG_H);
  localparam int JOB_W  = 1 + ADDR_W + 2 * COORD_W + COLOR_W;
  localparam int JCNT_W = $clog2(JOB_Q_DEPTH + 1);
  localparam int SUM_W  = JCNT_W + 1;

  // The front end maps screen pixels back into the sprite and classifies each
  // item. Everything it keeps (texel writes and hits) goes into the job queue.
  job_ctl_t           job_ctl;
  logic [ADDR_W-1:0]  fe_addr;
  logic [COORD_W-1:0] fe_col, fe_row;
  logic [COLOR_W-1:0] fe_color;
  logic [1:0]         busy_cnt;

  // Job queue read side, consumed by the memory back end.
  logic [JOB_W-1:0]   job_data;
  logic               job_empty, job_pop;
  logic [JCNT_W-1:0]  job_cnt;

  logic               in_accept;
  logic [SUM_W-1:0]   credit_sum;

  // The mapping stages never stall, so every item they hold needs a queue slot
  // reserved ahead of time. Full is a credit check over the queue and the stages.
  assign credit_sum = SUM_W'(job_cnt) + SUM_W'(busy_cnt);
  assign full       = credit_sum >= SUM_W'(JOB_Q_DEPTH);
  assign in_accept  = push && !full;

  rsb_front #(
    .MAX_IMG_W (MAX_IMG_W),
    .MAX_IMG_H (MAX_IMG_H)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .accept    (in_accept),
    .func      (in_func),
    .col       (in_col),
    .row       (in_row),
    .rgba      (in_rgba),
    .job_ctl   (job_ctl),
    .job_addr  (fe_addr),
    .job_col   (fe_col),
    .job_row   (fe_row),
    .job_color (fe_color),
    .busy_cnt  (busy_cnt)
  );

  rsb_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (JOB_Q_DEPTH)
  ) u_job_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_ctl.valid),
    .push_data ({job_ctl.write, fe_addr, fe_col, fe_row, fe_color}),
    .pop       (job_pop),
    .pop_data  (job_data),
    .empty     (job_empty),
    .count     (job_cnt)
  );

  // The back end owns the texel memory. Writes and reads come out of one queue in
  // item order, so a render always sees every load accepted before it.
  rsb_back #(
    .MAX_IMG_W (MAX_IMG_W),
    .MAX_IMG_H (MAX_IMG_H)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .job_empty      (job_empty),
    .job_write      (job_data[JOB_W-1]),
    .job_addr       (job_data[JOB_W-2 -: ADDR_W]),
    .job_col        (job_data[COLOR_W + COORD_W +: COORD_W]),
    .job_row        (job_data[COLOR_W +: COORD_W]),
    .job_color      (job_data[COLOR_W-1:0]),
    .job_pop        (job_pop),
    .out_pop        (pop),
    .out_empty      (empty),
    .out_screen_col (out_screen_col),
    .out_screen_row (out_screen_row),
    .out_color      (out_color)
  );

  // Items in the mapping stages plus queued jobs never exceed the queue depth.
  `RSB_ASSERT(a_job_credit, credit_sum <= SUM_W'(JOB_Q_DEPTH), "job credit overrun")

endmodule

// ----- rtl/rsb_fifo.sv -----
`include "assert_macros.svh"

module rsb_fifo #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  input  logic [WIDTH-1:0]               push_data,
  input  logic                           pop,
  output logic [WIDTH-1:0]               pop_data,
  output logic                           empty,
  output logic [$clog2(DEPTH+1)-1:0]     count
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data = slot_r[rd_ptr_r];
  assign empty    = (cnt_r == '0);
  assign count    = cnt_r;

  // The credit scheme upstream must keep every push inside the storage.
  `RSB_NEVER(a_fifo_no_overflow, push && (cnt_r == CNT_W'(DEPTH)), "queue push while full")
  `RSB_NEVER(a_fifo_no_underflow, pop && (cnt_r == '0), "queue pop while empty")

endmodule

// ----- rtl/rsb_front.sv -----
module rsb_front import rsb_pkg::*; #(
  parameter int MAX_IMG_W = MAX_IMG_W_DEF,
  parameter int MAX_IMG_H = MAX_IMG_H_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        cfg_we,
  input  logic [CFG_IDX_W-1:0]                        cfg_index,
  input  logic [CFG_DATA_W-1:0]                       cfg_wdata,
  input  logic                                        accept,
  input  logic                                        func,
  input  logic [COORD_W-1:0]                          col,
  input  logic [COORD_W-1:0]                          row,
  input  logic [RGBA_W-1:0]                           rgba,
  output job_ctl_t                                    job_ctl,
  output logic [idx_bits(MAX_IMG_W*MAX_IMG_H)-1:0]    job_addr,
  output logic [COORD_W-1:0]                          job_col,
  output logic [COORD_W-1:0]                          job_row,
  output logic [COLOR_W-1:0]                          job_color,
  output logic [1:0]                                  busy_cnt
);

  localparam int ADDR_W = idx_bits(MAX_IMG_W * MAX_IMG_H);
  localparam int CW     = idx_bits(MAX_IMG_W);
  localparam int RW     = idx_bits(MAX_IMG_H);
  localparam int SRC_W  = MAP_W - FRAC_W;

  // Configuration registers.
  logic signed [CENTER_W-1:0] center_x_r, center_y_r;
  logic signed [STEP_W-1:0]   step_cos_r, step_sin_r;
  logic [SIZE_W-1:0]          img_w_r, img_h_r;
  logic [SIZE_W-1:0]          w_eff, h_eff;

  // Stage 1: offsets from the centre and load classification.
  logic                      s1_valid_r, s1_func_r, s1_load_r;
  logic [COORD_W-1:0]        s1_col_r, s1_row_r;
  logic [COLOR_W-1:0]        s1_color_r;
  logic [ADDR_W-1:0]         s1_addr_r;
  logic signed [DELTA_W-1:0] s1_dx_r, s1_dy_r;

  // Stage 2: the four rotation products.
  logic                      s2_valid_r, s2_func_r, s2_load_r;
  logic [COORD_W-1:0]        s2_col_r, s2_row_r;
  logic [COLOR_W-1:0]        s2_color_r;
  logic [ADDR_W-1:0]         s2_addr_r;
  logic signed [PROD_W-1:0]  s2_pxc_r, s2_pys_r, s2_pxs_r, s2_pyc_r;

  // Stage 3: source coordinates in Q.20.
  logic                      s3_valid_r, s3_func_r, s3_load_r;
  logic [COORD_W-1:0]        s3_col_r, s3_row_r;
  logic [COLOR_W-1:0]        s3_color_r;
  logic [ADDR_W-1:0]         s3_addr_r;
  logic signed [MAP_W-1:0]   s3_u_r, s3_v_r;

  logic [COLOR_W-1:0]        s1_color_nxt;
  logic                      s1_load_nxt;
  logic [ADDR_W-1:0]         s1_addr_nxt;
  logic signed [DELTA_W-1:0] s1_dx_nxt, s1_dy_nxt;
  logic signed [MAP_W-1:0]   half_w, half_h, s3_u_nxt, s3_v_nxt;
  logic [SRC_W-1:0]          src_x, src_y;
  logic                      draw_ok;
  logic [ADDR_W-1:0]         draw_addr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= '0;
      center_y_r <= '0;
      step_cos_r <= STEP_COS_RST;
      step_sin_r <= '0;
      img_w_r    <= '0;
      img_h_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_CENTER_X:     center_x_r <= cfg_wdata[CENTER_W-1:0];
        CFG_CENTER_Y:     center_y_r <= cfg_wdata[CENTER_W-1:0];
        CFG_STEP_COS:     step_cos_r <= cfg_wdata[STEP_W-1:0];
        CFG_STEP_SIN:     step_sin_r <= cfg_wdata[STEP_W-1:0];
        CFG_IMAGE_WIDTH:  img_w_r    <= cfg_wdata[SIZE_W-1:0];
        CFG_IMAGE_HEIGHT: img_h_r    <= cfg_wdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Sizes beyond the memory are clipped to it.
  assign w_eff = (int'(img_w_r) > MAX_IMG_W) ? SIZE_W'(MAX_IMG_W) : img_w_r;
  assign h_eff = (int'(img_h_r) > MAX_IMG_H) ? SIZE_W'(MAX_IMG_H) : img_h_r;

  assign s1_color_nxt = rgb565(rgba);
  assign s1_dx_nxt    = $signed({3'b000, col, 4'b0000}) - DELTA_W'(center_x_r);
  assign s1_dy_nxt    = $signed({3'b000, row, 4'b0000}) - DELTA_W'(center_y_r);
  assign s1_load_nxt  = (col < COORD_W'(w_eff)) && (row < COORD_W'(h_eff));
  assign s1_addr_nxt  = ADDR_W'(row[RW-1:0]) * ADDR_W'(MAX_IMG_W) + ADDR_W'(col[CW-1:0]);

  assign half_w   = $signed({(MAP_W-SIZE_W-HALF_SHIFT)'(0), w_eff, HALF_SHIFT'(0)});
  assign half_h   = $signed({(MAP_W-SIZE_W-HALF_SHIFT)'(0), h_eff, HALF_SHIFT'(0)});
  assign s3_u_nxt = MAP_W'(s2_pxc_r) + MAP_W'(s2_pys_r) + half_w;
  assign s3_v_nxt = MAP_W'(s2_pyc_r) - MAP_W'(s2_pxs_r) + half_h;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_func_r  <= func;
    s1_col_r   <= col;
    s1_row_r   <= row;
    s1_color_r <= s1_color_nxt;
    s1_load_r  <= s1_load_nxt;
    s1_addr_r  <= s1_addr_nxt;
    s1_dx_r    <= s1_dx_nxt;
    s1_dy_r    <= s1_dy_nxt;

    s2_func_r  <= s1_func_r;
    s2_col_r   <= s1_col_r;
    s2_row_r   <= s1_row_r;
    s2_color_r <= s1_color_r;
    s2_load_r  <= s1_load_r;
    s2_addr_r  <= s1_addr_r;
    s2_pxc_r   <= PROD_W'(s1_dx_r * step_cos_r);
    s2_pys_r   <= PROD_W'(s1_dy_r * step_sin_r);
    s2_pxs_r   <= PROD_W'(s1_dx_r * step_sin_r);
    s2_pyc_r   <= PROD_W'(s1_dy_r * step_cos_r);

    s3_func_r  <= s2_func_r;
    s3_col_r   <= s2_col_r;
    s3_row_r   <= s2_row_r;
    s3_color_r <= s2_color_r;
    s3_load_r  <= s2_load_r;
    s3_addr_r  <= s2_addr_r;
    s3_u_r     <= s3_u_nxt;
    s3_v_r     <= s3_v_nxt;
  end

  // Floor to whole texels; a negative coordinate or one past the size misses.
  assign src_x   = s3_u_r[MAP_W-1:FRAC_W];
  assign src_y   = s3_v_r[MAP_W-1:FRAC_W];
  assign draw_ok = !s3_u_r[MAP_W-1] && !s3_v_r[MAP_W-1] &&
                   (src_x < SRC_W'(w_eff)) && (src_y < SRC_W'(h_eff));
  assign draw_addr = ADDR_W'(src_y[RW-1:0]) * ADDR_W'(MAX_IMG_W) + ADDR_W'(src_x[CW-1:0]);

  always_comb begin
    job_ctl.write = (func_t'(s3_func_r) == FUNC_LOAD);
    job_ctl.valid = s3_valid_r && (job_ctl.write ? s3_load_r : draw_ok);
    job_addr      = job_ctl.write ? s3_addr_r : draw_addr;
  end

  assign job_col   = s3_col_r;
  assign job_row   = s3_row_r;
  assign job_color = s3_color_r;
  assign busy_cnt  = 2'(s1_valid_r) + 2'(s2_valid_r) + 2'(s3_valid_r);

endmodule

// ----- rtl/rsb_back.sv -----
module rsb_back import rsb_pkg::*; #(
  parameter int MAX_IMG_W = MAX_IMG_W_DEF,
  parameter int MAX_IMG_H = MAX_IMG_H_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        job_empty,
  input  logic                                        job_write,
  input  logic [idx_bits(MAX_IMG_W*MAX_IMG_H)-1:0]    job_addr,
  input  logic [COORD_W-1:0]                          job_col,
  input  logic [COORD_W-1:0]                          job_row,
  input  logic [COLOR_W-1:0]                          job_color,
  output logic                                        job_pop,
  input  logic                                        out_pop,
  output logic                                        out_empty,
  output logic [COORD_W-1:0]                          out_screen_col,
  output logic [COORD_W-1:0]                          out_screen_row,
  output logic [COLOR_W-1:0]                          out_color
);

  localparam int MEM_DEPTH = MAX_IMG_W * MAX_IMG_H;
  localparam int OCNT_W    = $clog2(OUT_Q_DEPTH + 1);
  localparam int OUT_W     = 2 * COORD_W + COLOR_W;

  logic [COLOR_W-1:0] texel_mem [MEM_DEPTH];

  logic               rd_valid_r;
  logic [COORD_W-1:0] rd_col_r, rd_row_r;
  logic [COLOR_W-1:0] rd_color_r;
  logic [OCNT_W-1:0]  out_cnt;
  logic [OUT_W-1:0]   out_data;

  // Take a job only when the result queue has room for it and the read in flight.
  assign job_pop = !job_empty &&
                   ((OCNT_W + 1)'(out_cnt) + (OCNT_W + 1)'(rd_valid_r) <
                    (OCNT_W + 1)'(OUT_Q_DEPTH));

  always_ff @(posedge clk) begin
    if (job_pop && job_write) begin
      texel_mem[job_addr] <= job_color;
    end
    if (job_pop && !job_write) begin
      rd_color_r <= texel_mem[job_addr];
      rd_col_r   <= job_col;
      rd_row_r   <= job_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= job_pop && !job_write;
    end
  end

  rsb_fifo #(
    .WIDTH (OUT_W),
    .DEPTH (OUT_Q_DEPTH)
  ) u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (rd_valid_r),
    .push_data ({rd_col_r, rd_row_r, rd_color_r}),
    .pop       (out_pop && !out_empty),
    .pop_data  (out_data),
    .empty     (out_empty),
    .count     (out_cnt)
  );

  assign out_screen_col = out_data[OUT_W-1 -: COORD_W];
  assign out_screen_row = out_data[COLOR_W +: COORD_W];
  assign out_color      = out_data[COLOR_W-1:0];

endmodule

// ----- verif/tb_rotozoom_sprite_blitter.sv -----
module tb_rotozoom_sprite_blitter;
  import rsb_pkg::*;

  // One drawn pixel as it should leave the result queue.
  typedef struct {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [COLOR_W-1:0] color;
  } pixel_t;

  localparam int TEXELS = MAX_IMG_W_DEF * MAX_IMG_H_DEF;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  cfg_reg_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  push;
  logic                  full;
  func_t                 in_func;
  logic [COORD_W-1:0]    in_col;
  logic [COORD_W-1:0]    in_row;
  logic [RGBA_W-1:0]     in_rgba;
  logic                  empty;
  logic                  pop;
  logic [COORD_W-1:0]    out_screen_col;
  logic [COORD_W-1:0]    out_screen_row;
  logic [COLOR_W-1:0]    out_color;

  rotozoom_sprite_blitter uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .push           (push),
    .full           (full),
    .in_func        (in_func),
    .in_col         (in_col),
    .in_row         (in_row),
    .in_rgba        (in_rgba),
    .empty          (empty),
    .pop            (pop),
    .out_screen_col (out_screen_col),
    .out_screen_row (out_screen_row),
    .out_color      (out_color)
  );

  // Our own copy of the register file, updated whenever the test writes it.
  logic signed [CENTER_W-1:0] ctr_x;
  logic signed [CENTER_W-1:0] ctr_y;
  logic signed [STEP_W-1:0]   stp_cos;
  logic signed [STEP_W-1:0]   stp_sin;
  logic [SIZE_W-1:0]          img_w;
  logic [SIZE_W-1:0]          img_h;

  // Mirror of the texel memory. The loaded flags let the stimulus steer clear
  // of texels that were never written, whose contents are undefined.
  logic [COLOR_W-1:0] texel_copy [TEXELS];
  bit                 texel_loaded [TEXELS];

  // Pixels that the block still owes us, oldest first.
  pixel_t pending_pixels [$];
  pixel_t want;

  int fail_count = 0;
  int idle_pct   = 0;  // chance in percent that the sender skips a cycle
  int stall_pct  = 0;  // chance in percent that the receiver holds pop low
  int hold_asked = 0;  // bumped by a test to request one long receiver hold-off
  int hold_taken = 0;
  int hold_left  = 0;

  always #5 clk = ~clk;

  // The generous limit covers about a thousand items with both sides idling
  // about half the time, plus the long hold-offs. A correct run ends far earlier.
  initial begin
    #5000000;
    $display("== FAIL ==");
    $finish;
  end

  // Sizes above the memory bound are clipped by the block, so do the same here.
  function automatic int eff_size(input logic [SIZE_W-1:0] s, input int lim);
    return (s > lim) ? lim : int'(s);
  endfunction

  // Inverse mapping of one screen pixel into the sprite. Returns 1 when the
  // pixel lands inside the sprite and gives the source texel back.
  function automatic bit map_pixel(input logic [COORD_W-1:0] col,
                                   input logic [COORD_W-1:0] row,
                                   output int sx, output int sy);
    longint w;
    longint h;
    longint dx;
    longint dy;
    longint u;
    longint v;
    w  = eff_size(img_w, MAX_IMG_W_DEF);
    h  = eff_size(img_h, MAX_IMG_H_DEF);
    sx = 0;
    sy = 0;
    if (w == 0 || h == 0) return 0;
    dx = longint'(col) * 16 - longint'(ctr_x);
    dy = longint'(row) * 16 - longint'(ctr_y);
    // Deltas are Q.4 and steps Q.16, so the sums are Q.20; adding W/2 and H/2
    // moves the origin from the sprite centre to its top-left corner.
    u = dx * longint'(stp_cos) + dy * longint'(stp_sin) + (w <<< HALF_SHIFT);
    v = -dx * longint'(stp_sin) + dy * longint'(stp_cos) + (h <<< HALF_SHIFT);
    if (u < 0 || v < 0) return 0;
    u = u >>> FRAC_W;
    v = v >>> FRAC_W;
    if (u >= w || v >= h) return 0;
    sx = int'(u);
    sy = int'(v);
    return 1;
  endfunction

  // A render is safe to send unless it would sample a texel never loaded.
  function automatic bit draw_is_safe(input logic [COORD_W-1:0] col,
                                      input logic [COORD_W-1:0] row);
    int sx;
    int sy;
    if (!map_pixel(col, row, sx, sy)) return 1;
    return texel_loaded[sy * MAX_IMG_W_DEF + sx];
  endfunction

  // Applies one accepted item to the mirror and queues the pixel it draws.
  function automatic void apply_item(input func_t f, input logic [COORD_W-1:0] col,
                                     input logic [COORD_W-1:0] row,
                                     input logic [RGBA_W-1:0] rgba);
    int sx;
    int sy;
    int addr;
    pixel_t px;
    if (f == FUNC_LOAD) begin
      // Loads outside the current sprite size are dropped without a trace.
      if (col < eff_size(img_w, MAX_IMG_W_DEF) && row < eff_size(img_h, MAX_IMG_H_DEF)) begin
        addr = int'(row) * MAX_IMG_W_DEF + int'(col);
        // Keep the top bits of red, green and blue; alpha is thrown away.
        texel_copy[addr]   = {rgba[31:27], rgba[23:18], rgba[15:11]};
        texel_loaded[addr] = 1;
      end
    end else if (map_pixel(col, row, sx, sy)) begin
      px.col   = col;
      px.row   = row;
      px.color = texel_copy[sy * MAX_IMG_W_DEF + sx];
      pending_pixels.push_back(px);
    end
  endfunction

  // Offers one item from a falling edge and returns at the falling edge after
  // the block took it. Push stays high on return, so the next call can chain a
  // new item without a bubble; every other path lowers push itself.
  task automatic send_item(input func_t f, input logic [COORD_W-1:0] col,
                           input logic [COORD_W-1:0] row, input logic [RGBA_W-1:0] rgba);
    while ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push    <= 1'b1;
    in_func <= f;
    in_col  <= col;
    in_row  <= row;
    in_rgba <= rgba;
    @(posedge clk);
    while (full) @(posedge clk);
    apply_item(f, col, row, rgba);
    @(negedge clk);
  endtask

  task automatic send_draw(input int col, input int row);
    if (draw_is_safe(COORD_W'(col), COORD_W'(row)))
      send_item(FUNC_DRAW, COORD_W'(col), COORD_W'(row), $urandom());
  endtask

  // Stops sending and waits until every owed pixel is out. Renders that miss
  // and loads leave no trace, so a few more cycles let the pipe and the job
  // queue empty before anything touches the registers.
  task automatic drain();
    push <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
  endtask

  // Writes all six registers back to back. Only called with the block idle.
  task automatic set_config(input logic signed [CENTER_W-1:0] cx,
                            input logic signed [CENTER_W-1:0] cy,
                            input logic signed [STEP_W-1:0] cs,
                            input logic signed [STEP_W-1:0] sn,
                            input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
    write_reg(CFG_CENTER_X, cx);
    write_reg(CFG_CENTER_Y, cy);
    write_reg(CFG_STEP_COS, cs);
    write_reg(CFG_STEP_SIN, sn);
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
    cfg_we <= 1'b0;
    @(negedge clk);
    ctr_x   = cx;
    ctr_y   = cy;
    stp_cos = cs;
    stp_sin = sn;
    img_w   = w;
    img_h   = h;
  endtask

  // Loads every texel of the current sprite with random colors.
  task automatic fill_sprite();
    for (int r = 0; r < eff_size(img_h, MAX_IMG_H_DEF); r++)
      for (int c = 0; c < eff_size(img_w, MAX_IMG_W_DEF); c++)
        send_item(FUNC_LOAD, COORD_W'(c), COORD_W'(r), $urandom());
  endtask

  function automatic int clamp_coord(input int v);
    return (v < 0) ? 0 : (v > 1023) ? 1023 : v;
  endfunction

  // Random registers: small sprites, scales from about a quarter to four,
  // and an arbitrary mix of cosine and sine so the rotation is not orthogonal.
  task automatic random_config();
    int mag;
    int cs;
    int sn;
    mag = $urandom_range(16384, 262144);
    cs  = int'($urandom_range(0, 2 * mag)) - mag;
    sn  = int'($urandom_range(0, 2 * mag)) - mag;
    set_config(CENTER_W'($urandom_range(0, 16383)), CENTER_W'($urandom_range(0, 16383)),
               STEP_W'(cs), STEP_W'(sn),
               SIZE_W'($urandom_range(1, 8)), SIZE_W'($urandom_range(1, 8)));
  endtask

  // Mostly renders around the sprite centre, where they are likely to land,
  // plus loads that repaint the sprite under way and some noise.
  task automatic run_mix(input int count);
    int span;
    int stepmag;
    int k;
    int w;
    int h;
    w = eff_size(img_w, MAX_IMG_W_DEF);
    h = eff_size(img_h, MAX_IMG_H_DEF);
    stepmag = (stp_cos < 0 ? -int'(stp_cos) : int'(stp_cos)) +
              (stp_sin < 0 ? -int'(stp_sin) : int'(stp_sin));
    if (stepmag < 4096) stepmag = 4096;
    // Screen radius that covers the whole sprite at this scale.
    span = ((w + h) * 65536) / stepmag;
    if (span < 1) span = 1;
    if (span > 400) span = 400;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(99);
      if (k < 75)
        send_draw(clamp_coord(int'(ctr_x) / 16 + int'($urandom_range(0, 2 * span)) - span),
                  clamp_coord(int'(ctr_y) / 16 + int'($urandom_range(0, 2 * span)) - span));
      else if (k < 87)
        send_item(FUNC_LOAD, COORD_W'($urandom_range(0, w - 1)),
                  COORD_W'($urandom_range(0, h - 1)), $urandom());
      else if (k < 94)
        send_item(FUNC_LOAD, COORD_W'($urandom()), COORD_W'($urandom()), $urandom());
      else
        send_draw($urandom_range(0, 1023), $urandom_range(0, 1023));
    end
  endtask

  // Straight after reset the sprite has no size: renders draw nothing and
  // loads are dropped.
  task automatic test_empty_sprite();
    send_draw(0, 0);
    send_draw(1023, 1023);
    send_item(FUNC_LOAD, '0, '0, 32'hFFFF_FFFF);
    send_item(FUNC_DRAW, 10'd512, 10'd512, 32'h0);
    drain();
  endtask

  // Unit scale, no rotation, 8x8 sprite centred on pixel (8,8): screen
  // columns 4 to 11 cover texels 0 to 7.
  task automatic test_unit_scale();
    set_config(16'sd128, 16'sd128, 24'sd65536, 24'sd0, 8'd8, 8'd8);
    fill_sprite();
    // Color extremes, with alpha set and cleared to show it has no effect.
    send_item(FUNC_LOAD, 10'd0, 10'd0, 32'hFFFF_FF00);
    send_item(FUNC_LOAD, 10'd7, 10'd7, 32'h0000_00FF);
    send_item(FUNC_LOAD, 10'd3, 10'd5, 32'h0707_03AA);
    // Loads just outside the sprite and at the far corner of the field.
    send_item(FUNC_LOAD, 10'd8, 10'd0, 32'h1234_5678);
    send_item(FUNC_LOAD, 10'd0, 10'd8, 32'h1234_5678);
    send_item(FUNC_LOAD, 10'd1023, 10'd1023, 32'hFFFF_FFFF);
    send_draw(4, 4);
    send_draw(11, 11);
    send_draw(7, 9);
    send_draw(3, 4);
    send_draw(12, 4);
    send_draw(4, 12);
    drain();
    // A zero height or a zero width alone disables drawing.
    set_config(16'sd128, 16'sd128, 24'sd65536, 24'sd0, 8'd8, 8'd0);
    send_draw(4, 4);
    drain();
    set_config(16'sd128, 16'sd128, 24'sd65536, 24'sd0, 8'd0, 8'd8);
    send_draw(4, 4);
    drain();
  endtask

  // Register extremes, mirrored and quarter-turn mappings, and oversize widths.
  task automatic test_register_extremes();
    // Zero steps: every screen pixel collapses onto the centre texel.
    set_config(-16'sd32768, 16'sd32767, 24'sd0, 24'sd0, 8'd8, 8'd8);
    send_draw(0, 0);
    send_draw(1023, 1023);
    send_draw(512, 100);
    drain();
    // Half turn and quarter turn about pixel (8,8).
    set_config(16'sd128, 16'sd128, -24'sd65536, 24'sd0, 8'd8, 8'd8);
    for (int c = 3; c <= 12; c += 3) send_draw(c, 13 - c);
    drain();
    set_config(16'sd128, 16'sd128, 24'sd0, 24'sd65536, 8'd8, 8'd8);
    for (int c = 4; c <= 12; c += 4) send_draw(c, c - 1);
    drain();
    // Steepest steps: only the pixel right at the centre stays inside.
    set_config(16'sd0, 16'sd0, -24'sd8388608, 24'sd8388607, 8'd8, 8'd8);
    send_draw(0, 0);
    send_draw(1, 0);
    send_draw(0, 1);
    drain();
    set_config(16'sd32767, -16'sd32768, 24'sd8388607, -24'sd8388608, 8'd128, 8'd128);
    send_draw(1023, 0);
    send_draw(0, 0);
    drain();
    // A width above the memory bound acts as the bound: 128 texels in one row.
    set_config(16'sd1024, 16'sd0, 24'sd65536, 24'sd0, 8'd255, 8'd1);
    fill_sprite();
    send_item(FUNC_LOAD, 10'd200, 10'd0, 32'hDEAD_BEEF);
    send_draw(0, 0);
    send_draw(127, 0);
    send_draw(128, 0);
    send_draw(64, 1);
    drain();
    set_config(16'sd16, 16'sd1024, 24'sd65536, 24'sd0, 8'd1, 8'd255);
    fill_sprite();
    send_draw(0, 0);
    send_draw(0, 127);
    send_draw(0, 128);
    drain();
  endtask

  // Random registers and traffic, once per idling pattern.
  task automatic test_random_traffic();
    for (int phase = 0; phase < 4; phase++) begin
      drain();
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 53; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 53; end
        default: begin idle_pct = 34; stall_pct = 34; end
      endcase
      random_config();
      fill_sprite();
      run_mix(115);
    end
    drain();
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering
  // renders that all land, so the result queue and the job queue fill and
  // full has to hold the sender back. Then the sender waits for every pixel.
  task automatic test_backpressure();
    idle_pct  = 0;
    stall_pct = 0;
    set_config(16'sd128, 16'sd128, 24'sd65536, 24'sd0, 8'd8, 8'd8);
    hold_asked <= hold_asked + 1;
    @(negedge clk);
    for (int i = 0; i < 40; i++) send_draw($urandom_range(4, 11), $urandom_range(4, 11));
    drain();
  endtask

  // Receiver: pop is driven at the falling edge, randomly held low as the
  // current phase asks, or held low for a whole stretch on request.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      pop       <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_asked != hold_taken) begin
      pop        <= 1'b0;
      hold_taken <= hold_asked;
      hold_left  <= 80;
    end else begin
      pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Checker: every pixel taken from the block must match the oldest one owed.
  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected pixel col %0d row %0d color %h",
               out_screen_col, out_screen_row, out_color);
        fail_count++;
      end else begin
        want = pending_pixels.pop_front();
        if (out_screen_col !== want.col) begin
          $error("screen_col: expected %0d, actual %0d", want.col, out_screen_col);
          fail_count++;
        end
        if (out_screen_row !== want.row) begin
          $error("screen_row: expected %0d, actual %0d", want.row, out_screen_row);
          fail_count++;
        end
        if (out_color !== want.color) begin
          $error("color: expected %h, actual %h", want.color, out_color);
          fail_count++;
        end
      end
    end
  end

  initial begin
    int guard;
    clk       = 1'b0;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = CFG_CENTER_X;
    cfg_wdata = '0;
    push      = 1'b0;
    pop       = 1'b0;
    in_func   = FUNC_LOAD;
    in_col    = '0;
    in_row    = '0;
    in_rgba   = '0;
    // Mirror of the reset values of the registers.
    ctr_x   = '0;
    ctr_y   = '0;
    stp_cos = STEP_COS_RST;
    stp_sin = '0;
    img_w   = '0;
    img_h   = '0;
    foreach (texel_loaded[i]) texel_loaded[i] = 0;

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_empty_sprite();
    test_unit_scale();
    test_register_extremes();
    test_random_traffic();
    test_backpressure();

    // Let the last pixels out with the receiver always ready.
    push     <= 1'b0;
    stall_pct = 0;
    for (guard = 0; guard < 10000 && pending_pixels.size() != 0; guard++) @(negedge clk);
    repeat (20) @(negedge clk);
    if (pending_pixels.size() != 0) begin
      $error("%0d pixels never came out", pending_pixels.size());
      fail_count++;
    end
    if (fail_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- rotozoom_sprite_blitter.f -----
+incdir+rtl
rtl/rsb_pkg.sv
rtl/rsb_fifo.sv
rtl/rsb_front.sv
rtl/rsb_back.sv
rtl/rotozoom_sprite_blitter.sv
verif/tb_rotozoom_sprite_blitter.sv
